[rtl/core/priority_thread_cpu_assigner_top_assert.svh]
// ----------------------------------------------------------------------------
// priority thread cpu assigner assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_THREAD_CPU_ASSIGNER_TOP_ASSERT_SVH
`define PRIORITY_THREAD_CPU_ASSIGNER_TOP_ASSERT_SVH

`ifndef SYNTH

// property checked on every clock edge out of reset
`define PTCA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold out of reset
`define PTCA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define PTCA_ASSERT(lbl, clk, rst_n, prop, msg)

`define PTCA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[rtl/core/ptca_pkg.sv]
// ----------------------------------------------------------------------------
// ptca_pkg
// Shared constants, request codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package ptca_pkg;

	localparam int TABLE_SLOTS = 8;
	localparam int CPU_COUNT   = 8;
	localparam int LEVEL_MAX   = 8;
	localparam int ORDER_LEN   = 8;

	localparam int SLOT_W = $clog2(TABLE_SLOTS);
	localparam int RANK_W = $clog2(TABLE_SLOTS) + 1;
	localparam int ID_W   = 4;
	localparam int LVL_W  = 4;
	localparam int TID_W  = 22;
	localparam int REQ_W  = 3;
	localparam int MASK_W = 8;
	localparam int ORDER_W = ORDER_LEN * ID_W;

	localparam logic [MASK_W-1:0] CPU_ALL = MASK_W'((1 << CPU_COUNT) - 1);
	localparam logic [ID_W-1:0]   CORE_NONE = 4'hf;

	localparam logic [ORDER_W-1:0] CPU_ORDER_RESET   = 32'hff562347;
	localparam logic [MASK_W-1:0]  ONLINE_MASK_RESET = 8'hff;

	// register indexes on the config port
	localparam logic REG_CPU_ORDER   = 1'b0;
	localparam logic REG_ONLINE_MASK = 1'b1;

	// request codes
	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_RECOMP = 3'd3;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_UPDATE = 6'b000010,
		ST_PREP   = 6'b000100,
		ST_RANK   = 6'b001000,
		ST_PICK   = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic update;
		logic prep;
		logic rank;
		logic pick;
	} cmd_t;

	typedef struct packed {
		logic need_reassign;
		logic last_slot;
	} status_t;

endpackage

`default_nettype wire

[rtl/core/ptca_ctrl.sv]
// ----------------------------------------------------------------------------
// ptca_ctrl
// Sequencer: table update, then, if reassignment is needed, a prep step and a rank/pick pass over every slot.
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_thread_cpu_assigner_top_assert.svh"

module ptca_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire ptca_pkg::status_t sts,
	output ptca_pkg::cmd_t         cmd,
	output logic                   busy,
	output logic                   done
);
	import ptca_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = sts.need_reassign ? ST_PREP : ST_DONE;
			end
			ST_PREP: begin
				state_d = ST_RANK;
			end
			ST_RANK: begin
				state_d = ST_PICK;
			end
			ST_PICK: begin
				state_d = sts.last_slot ? ST_DONE : ST_RANK;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.update = (state_q == ST_UPDATE);
		cmd.prep   = (state_q == ST_PREP);
		cmd.rank   = (state_q == ST_RANK);
		cmd.pick   = (state_q == ST_PICK);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	`PTCA_ASSERT(a_accept_to_update, clk, arst_n, (state_q == ST_IDLE && start) |=> (state_q == ST_UPDATE), "accepted word did not enter update")
	`PTCA_ASSERT(a_done_one_cycle, clk, arst_n, (state_q == ST_DONE) |=> (state_q == ST_IDLE), "done strobe longer than one cycle")
	`PTCA_ASSERT(a_pick_walks_on, clk, arst_n, (state_q == ST_PICK && !sts.last_slot) |=> (state_q == ST_RANK), "slot walk ended early")

endmodule

`default_nettype wire

[rtl/core/ptca_dp.sv]
// ----------------------------------------------------------------------------
// ptca_dp
// Thread table, request update logic and per-slot cpu assignment datapath.
// ----------------------------------------------------------------------------
`default_nettype none
`include "priority_thread_cpu_assigner_top_assert.svh"

module ptca_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire ptca_pkg::cmd_t                       cmd,
	output ptca_pkg::status_t                         sts,
	input  wire logic [ptca_pkg::ORDER_W-1:0]         cpu_order,
	input  wire logic [ptca_pkg::MASK_W-1:0]          online_mask,
	input  wire logic [ptca_pkg::REQ_W-1:0]           req_type,
	input  wire logic [ptca_pkg::TID_W-1:0]           thread_id,
	input  wire logic [ptca_pkg::LVL_W-1:0]           priority_req,
	input  wire logic                                 task_found,
	input  wire logic [ptca_pkg::SLOT_W-1:0]          query_slot,
	output logic                                      changed,
	output logic [ptca_pkg::SLOT_W-1:0]               slot_taken,
	output logic signed [ptca_pkg::ID_W-1:0]          slot_cpu,
	output logic                                      preempt_hint,
	output logic [ptca_pkg::MASK_W-1:0]               busy_cpus
);
	import ptca_pkg::*;

	// thread table
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [TID_W-1:0]       thread_q [TABLE_SLOTS];
	logic [LVL_W-1:0]       level_q  [TABLE_SLOTS];
	logic [ID_W-1:0]        core_q   [TABLE_SLOTS];
	logic [MASK_W-1:0]      assigned_q;

	// captured request
	logic [REQ_W-1:0]  req_q;
	logic [TID_W-1:0]  tid_q;
	logic [LVL_W-1:0]  lvl_q;
	logic              found_q;
	logic [SLOT_W-1:0] qs_q;

	// result and walk state
	logic              changed_q;
	logic [SLOT_W-1:0] taken_q;
	logic [SLOT_W-1:0] slot_q;
	logic [RANK_W-1:0] pos_q;
	logic [MASK_W-1:0] avail_q;

	// lookup
	logic [TABLE_SLOTS-1:0] hit_vec;
	logic [TABLE_SLOTS-1:0] diff_vec;
	logic                   hit_any;
	logic                   free_any;
	logic [SLOT_W-1:0]      hit_idx;
	logic [SLOT_W-1:0]      free_idx;

	logic              upd_changed;
	logic              upd_reassign;
	logic [SLOT_W-1:0] upd_taken;

	logic add_hit;
	logic add_new;
	logic rem_hit;
	logic clr_all;

	logic [LVL_W-1:0]  lvl_sel;
	logic [RANK_W-1:0] rank_cnt;
	logic              pick_ok;
	logic [ID_W-1:0]   pick_id;
	logic [MASK_W-1:0] avail_now;

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			hit_vec[i]  = valid_q[i] && (thread_q[i] == tid_q);
			diff_vec[i] = (level_q[i] != lvl_q);
		end
		for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) hit_idx = SLOT_W'(i);
			if (!valid_q[i]) free_idx = SLOT_W'(i);
		end
		hit_any  = |hit_vec;
		free_any = ~&valid_q;
	end

	always_comb begin
		upd_changed  = 1'b0;
		upd_reassign = 1'b0;
		upd_taken    = '0;
		unique case (req_q)
			REQ_ADD: begin
				if (hit_any) begin
					upd_taken   = hit_idx;
					upd_changed = diff_vec[hit_idx];
				end else if (free_any && found_q) begin
					upd_taken   = free_idx;
					upd_changed = 1'b1;
				end
				upd_reassign = upd_changed;
			end
			REQ_REMOVE: begin
				if (hit_any) begin
					upd_taken    = hit_idx;
					upd_changed  = 1'b1;
					upd_reassign = 1'b1;
				end
			end
			REQ_CLEAR: begin
				upd_changed = 1'b1;
			end
			REQ_RECOMP: begin
				upd_changed  = 1'b1;
				upd_reassign = 1'b1;
			end
			default: begin
				upd_changed = 1'b0;
			end
		endcase
	end

	assign add_hit = cmd.update && (req_q == REQ_ADD) && hit_any && diff_vec[hit_idx];
	assign add_new = cmd.update && (req_q == REQ_ADD) && !hit_any && free_any && found_q;
	assign rem_hit = cmd.update && (req_q == REQ_REMOVE) && hit_any;
	assign clr_all = cmd.update && (req_q == REQ_CLEAR);

	// rank: occupied slots strictly more critical than the current one
	always_comb begin
		lvl_sel  = level_q[slot_q];
		rank_cnt = '0;
		for (int j = 0; j < TABLE_SLOTS; j++) begin
			rank_cnt = rank_cnt + RANK_W'(valid_q[j] && (level_q[j] < lvl_sel));
		end
	end

	// pick: first online free cpu at or after the rank position, end marker stops
	always_comb begin
		logic            stop;
		logic [ID_W-1:0] ord_id;
		stop    = 1'b0;
		pick_ok = 1'b0;
		pick_id = '0;
		for (int p = 0; p < ORDER_LEN; p++) begin
			ord_id = cpu_order[p*ID_W +: ID_W];
			if (!stop && (RANK_W'(p) >= pos_q)) begin
				if (ord_id[ID_W-1]) begin
					stop = 1'b1;
				end else if ((ord_id < ID_W'(CPU_COUNT)) && avail_q[ord_id[ID_W-2:0]]) begin
					pick_ok = 1'b1;
					pick_id = ord_id;
					stop    = 1'b1;
				end
			end
		end
	end

	assign avail_now = online_mask & CPU_ALL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			assigned_q <= '0;
			avail_q    <= '0;
			slot_q     <= '0;
			for (int i = 0; i < TABLE_SLOTS; i++) core_q[i] <= CORE_NONE;
		end else begin
			if (add_new) begin
				valid_q[free_idx] <= 1'b1;
				core_q[free_idx]  <= CORE_NONE;
			end
			if (rem_hit) begin
				valid_q[hit_idx] <= 1'b0;
				core_q[hit_idx]  <= CORE_NONE;
			end
			if (clr_all) begin
				valid_q    <= '0;
				assigned_q <= '0;
				for (int i = 0; i < TABLE_SLOTS; i++) core_q[i] <= CORE_NONE;
			end
			if (cmd.prep) begin
				// no online cpu empties the table
				if (avail_now == '0) valid_q <= '0;
				for (int i = 0; i < TABLE_SLOTS; i++) core_q[i] <= CORE_NONE;
				assigned_q <= '0;
				avail_q    <= avail_now;
				slot_q     <= '0;
			end
			if (cmd.pick) begin
				if (valid_q[slot_q] && pick_ok) begin
					core_q[slot_q]                 <= pick_id;
					avail_q[pick_id[ID_W-2:0]]     <= 1'b0;
					assigned_q[pick_id[ID_W-2:0]]  <= 1'b1;
				end
				slot_q <= sts.last_slot ? '0 : slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			tid_q   <= thread_id;
			lvl_q   <= (priority_req > LVL_W'(LEVEL_MAX)) ? LVL_W'(LEVEL_MAX) : priority_req;
			found_q <= task_found;
			qs_q    <= query_slot;
		end
		if (cmd.update) begin
			changed_q <= upd_changed;
			taken_q   <= upd_taken;
		end
		if (add_hit) begin
			level_q[hit_idx] <= lvl_q;
		end
		if (add_new) begin
			thread_q[free_idx] <= tid_q;
			level_q[free_idx]  <= lvl_q;
		end
		if (cmd.rank) begin
			pos_q <= rank_cnt;
		end
	end

	assign sts.need_reassign = upd_reassign;
	assign sts.last_slot     = (slot_q == SLOT_W'(TABLE_SLOTS - 1));

	assign changed      = changed_q;
	assign slot_taken   = taken_q;
	assign slot_cpu     = core_q[qs_q];
	assign preempt_hint = !core_q[qs_q][ID_W-1];
	assign busy_cpus    = assigned_q;

	`PTCA_ASSERT_NEVER(a_avail_assigned_disjoint, clk, arst_n, (avail_q & assigned_q) != '0, "cpu both free and assigned")
	`PTCA_ASSERT(a_reassign_implies_changed, clk, arst_n, (cmd.update && sts.need_reassign) |=> changed_q, "reassign without change flag")

endmodule

`default_nettype wire

[rtl/core/priority_thread_cpu_assigner_top.sv]
// Sequence: done pulses after start is taken, following update alone when the table needs no
// reassignment, or update, prep, and rank and pick per slot when it does.
// A new word is taken only while busy is low; busy stays high through the done cycle.
// Reset: table empty, every slot cpu -1, busy mask 0, registers at defaults.
// The result is on the ports for the single done cycle; it cannot be stalled.
// ----------------------------------------------------------------------------
// priority thread cpu assigner
// Critical thread table with cpu reassignment and an APB config port.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_thread_cpu_assigner_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [2:0]                           paddr,
	input  wire logic [31:0]                          pwdata,
	output logic [31:0]                               prdata,
	output logic                                      pready,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [ptca_pkg::REQ_W-1:0]           req_type,
	input  wire logic [ptca_pkg::TID_W-1:0]           thread_id,
	input  wire logic [ptca_pkg::LVL_W-1:0]           priority_req,
	input  wire logic                                 task_found,
	input  wire logic [ptca_pkg::SLOT_W-1:0]          query_slot,
	output logic                                      done,
	output logic                                      changed,
	output logic [ptca_pkg::SLOT_W-1:0]               slot_taken,
	output logic signed [ptca_pkg::ID_W-1:0]          slot_cpu,
	output logic                                      preempt_hint,
	output logic [ptca_pkg::MASK_W-1:0]               busy_cpus
);
	import ptca_pkg::*;

	logic [ORDER_W-1:0] cpu_order_q;
	logic [MASK_W-1:0]  online_mask_q;
	logic               reg_wr;
	logic               reg_idx;
	cmd_t               cmd;
	status_t            sts;

	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_order_q   <= CPU_ORDER_RESET;
			online_mask_q <= ONLINE_MASK_RESET;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_CPU_ORDER:   cpu_order_q   <= pwdata;
				REG_ONLINE_MASK: online_mask_q <= pwdata[MASK_W-1:0];
				default:         cpu_order_q   <= cpu_order_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CPU_ORDER:   prdata = cpu_order_q;
			REG_ONLINE_MASK: prdata = {{(32-MASK_W){1'b0}}, online_mask_q};
			default:         prdata = '0;
		endcase
	end

	ptca_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ptca_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cpu_order    (cpu_order_q),
		.online_mask  (online_mask_q),
		.req_type     (req_type),
		.thread_id    (thread_id),
		.priority_req (priority_req),
		.task_found   (task_found),
		.query_slot   (query_slot),
		.changed      (changed),
		.slot_taken   (slot_taken),
		.slot_cpu     (slot_cpu),
		.preempt_hint (preempt_hint),
		.busy_cpus    (busy_cpus)
	);

endmodule

`default_nettype wire
